// File: sv/onewire_rom_search_engine_assert.svh
// Assertion macros shared by the search engine modules.
`ifndef ONEWIRE_ROM_SEARCH_ENGINE_ASSERT_SVH
`define ONEWIRE_ROM_SEARCH_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF
// Check prop at every rising edge outside reset.
`define ROS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("search engine assertion failed");
// Check that cond never holds at a rising edge outside reset.
`define ROS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("search engine forbidden condition seen");
`else
`define ROS_ASSERT(lbl, clk, rst_n, prop)
`define ROS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// File: sv/ros_pkg.sv
package ros_pkg;

  localparam int unsigned RomBits       = 64;
  localparam int unsigned FamilyLimit   = 9;
  localparam int unsigned QueueDepthDef = 2;
  localparam logic [7:0]  CrcPoly       = 8'h8C;

  typedef enum logic [1:0] {
    FUNC_BEGIN    = 2'd0,
    FUNC_PRESENCE = 2'd1,
    FUNC_PAIR     = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_RESET  = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_DIR    = 2'd2,
    KIND_FINISH = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESENCE = 2'd1,
    PH_SEARCH   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [1:0] func;
    logic       restart;
    logic       present;
    logic       id_bit;
    logic       cmp_bit;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        dir_bit;
    logic        found;
    logic [63:0] rom_code;
    logic        was_last_device;
    logic [3:0]  family_branch;
    logic        last_of_run;
  } res_t;

  // One queue entry carries every result caused by one request.
  typedef struct packed {
    kind_e       kind0;
    logic        dir0;
    logic        found0;
    logic        last_dev0;
    logic [3:0]  fam0;
    logic        two;
    logic        found1;
    logic        last_dev1;
    logic [3:0]  fam1;
    logic [63:0] rom;
  } entry_t;

  // Reflected CRC-8, one data bit per step, LSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       mix;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      mix = c[0] ^ data[i];
      c   = {1'b0, c[7:1]};
      if (mix) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

endpackage

// File: sv/ros_front.sv
`include "onewire_rom_search_engine_assert.svh"

module ros_front import ros_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   accept_i,
  input  req_t   req_i,
  output logic   push_o,
  output entry_t entry_o
);

  phase_e      phase_q, phase_d;
  logic [6:0]  prev_q, prev_d;
  logic [3:0]  fam_q, fam_d;
  logic        nmd_q, nmd_d;
  logic [63:0] rom_q, rom_d;
  logic [7:0]  crc_q, crc_d;
  logic [6:0]  bp_q, bp_d;
  logic [6:0]  zta_q, zta_d;

  logic        is_begin, is_pres, is_pair;
  logic        nmd_begin;
  logic        both_one, differ, dir, take_zero, last_bit, end_ok;
  logic [6:0]  bp_eff, zta_new;
  logic [5:0]  idx;
  logic [3:0]  fam_new;
  logic [63:0] rom_new;
  logic [7:0]  byte_new, crc_new;

  assign is_begin = accept_i && (req_i.func == FUNC_BEGIN);
  assign is_pres  = accept_i && (req_i.func == FUNC_PRESENCE) && (phase_q == PH_PRESENCE);
  assign is_pair  = accept_i && (req_i.func == FUNC_PAIR) && (phase_q == PH_SEARCH);

  assign nmd_begin = req_i.restart ? 1'b0 : nmd_q;

  // Bit decision datapath.
  always_comb begin
    bp_eff = ((bp_q == 7'd0) || (bp_q > 7'(RomBits))) ? 7'd1 : bp_q;
    idx    = 6'(bp_eff - 7'd1);
    both_one = req_i.id_bit && req_i.cmp_bit;
    differ   = req_i.id_bit ^ req_i.cmp_bit;
    if (differ) begin
      dir = req_i.id_bit;
    end else if (bp_eff < prev_q) begin
      dir = rom_q[idx];
    end else begin
      dir = (bp_eff == prev_q);
    end
    take_zero = !differ && !dir;
    zta_new   = take_zero ? bp_eff : zta_q;
    fam_new   = (take_zero && (bp_eff < 7'(FamilyLimit))) ? bp_eff[3:0] : fam_q;
    rom_new      = rom_q;
    rom_new[idx] = dir;
    byte_new = rom_new[{idx[5:3], 3'b000} +: 8];
    crc_new  = (idx[2:0] == 3'd7) ? crc8_byte(crc_q, byte_new) : crc_q;
    last_bit = (idx == 6'(RomBits - 1));
    end_ok   = (crc_new == 8'd0) && (rom_new[7:0] != 8'd0);
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (is_begin) begin
      phase_d = nmd_begin ? PH_IDLE : PH_PRESENCE;
    end else if (is_pres) begin
      phase_d = req_i.present ? PH_SEARCH : PH_IDLE;
    end else if (is_pair && (both_one || last_bit)) begin
      phase_d = PH_IDLE;
    end
  end

  // Search state and queue entry.
  always_comb begin
    prev_d  = prev_q;
    fam_d   = fam_q;
    nmd_d   = nmd_q;
    rom_d   = rom_q;
    crc_d   = crc_q;
    bp_d    = bp_q;
    zta_d   = zta_q;
    push_o  = 1'b0;
    entry_o = '{kind0: KIND_FINISH, default: '0};
    entry_o.rom = rom_q;
    if (is_begin) begin
      push_o = 1'b1;
      bp_d   = 7'd1;
      zta_d  = '0;
      crc_d  = '0;
      if (req_i.restart || nmd_begin) begin
        prev_d = '0;
        nmd_d  = 1'b0;
        fam_d  = '0;
      end
      entry_o.kind0 = nmd_begin ? KIND_FINISH : KIND_RESET;
      entry_o.fam0  = (req_i.restart || nmd_begin) ? 4'd0 : fam_q;
    end else if (is_pres) begin
      push_o        = 1'b1;
      entry_o.fam0  = fam_q;
      entry_o.kind0 = KIND_SEARCH;
      if (!req_i.present) begin
        prev_d        = '0;
        nmd_d         = 1'b0;
        fam_d         = '0;
        entry_o.kind0 = KIND_FINISH;
        entry_o.fam0  = '0;
      end
    end else if (is_pair) begin
      push_o = 1'b1;
      if (both_one) begin
        prev_d        = '0;
        nmd_d         = 1'b0;
        fam_d         = '0;
        entry_o.kind0 = KIND_FINISH;
      end else begin
        rom_d         = rom_new;
        crc_d         = crc_new;
        zta_d         = zta_new;
        fam_d         = fam_new;
        bp_d          = bp_eff + 7'd1;
        entry_o.kind0 = KIND_DIR;
        entry_o.dir0  = dir;
        entry_o.fam0  = fam_new;
        entry_o.rom   = rom_new;
        if (last_bit) begin
          entry_o.two = 1'b1;
          if (end_ok) begin
            prev_d            = zta_new;
            nmd_d             = (zta_new == 7'd0) ? 1'b1 : nmd_q;
            entry_o.found1    = 1'b1;
            entry_o.last_dev1 = (zta_new == 7'd0) ? 1'b1 : nmd_q;
            entry_o.fam1      = fam_new;
          end else begin
            prev_d = '0;
            nmd_d  = 1'b0;
            fam_d  = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      prev_q  <= '0;
      fam_q   <= '0;
      nmd_q   <= 1'b0;
      rom_q   <= '0;
      crc_q   <= '0;
      bp_q    <= 7'd1;
      zta_q   <= '0;
    end else begin
      phase_q <= phase_d;
      prev_q  <= prev_d;
      fam_q   <= fam_d;
      nmd_q   <= nmd_d;
      rom_q   <= rom_d;
      crc_q   <= crc_d;
      bp_q    <= bp_d;
      zta_q   <= zta_d;
    end
  end

  `ROS_ASSERT(a_search_pos_range, clk_i, rst_ni, (phase_q == PH_SEARCH) |-> ((bp_q >= 7'd1) && (bp_q <= 7'(RomBits))))
  `ROS_ASSERT(a_last_dev_no_disc, clk_i, rst_ni, nmd_q |-> (prev_q == 7'd0))
  `ROS_ASSERT(a_two_after_dir, clk_i, rst_ni, (push_o && entry_o.two) |-> (entry_o.kind0 == KIND_DIR))

endmodule

// File: sv/ros_queue.sv
`include "onewire_rom_search_engine_assert.svh"

module ros_queue import ros_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `ROS_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(Depth))
  `ROS_ASSERT_NEVER(a_push_dropped, clk_i, rst_ni, push_i && full_o)

endmodule

// File: sv/ros_back.sv
`include "onewire_rom_search_engine_assert.svh"

module ros_back import ros_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  entry_t head_i,
  input  logic   empty_i,
  input  logic   pop_i,
  output logic   pop_entry_o,
  output res_t   res_o
);

  logic sub_q, sub_d;
  logic take;

  assign take = pop_i && !empty_i;

  // Advance within a two-result entry before releasing it.
  always_comb begin
    sub_d       = sub_q;
    pop_entry_o = 1'b0;
    if (take) begin
      if (!sub_q && head_i.two) begin
        sub_d = 1'b1;
      end else begin
        sub_d       = 1'b0;
        pop_entry_o = 1'b1;
      end
    end
  end

  always_comb begin
    res_o.rom_code = head_i.rom;
    if (sub_q) begin
      res_o.kind            = KIND_FINISH;
      res_o.dir_bit         = 1'b0;
      res_o.found           = head_i.found1;
      res_o.was_last_device = head_i.last_dev1;
      res_o.family_branch   = head_i.fam1;
      res_o.last_of_run     = 1'b1;
    end else begin
      res_o.kind            = head_i.kind0;
      res_o.dir_bit         = head_i.dir0;
      res_o.found           = head_i.found0;
      res_o.was_last_device = head_i.last_dev0;
      res_o.family_branch   = head_i.fam0;
      res_o.last_of_run     = !head_i.two;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
    end else begin
      sub_q <= sub_d;
    end
  end

  `ROS_ASSERT(a_sub_needs_two, clk_i, rst_ni, sub_q |-> (!empty_i && head_i.two))
  `ROS_ASSERT(a_second_follows, clk_i, rst_ni, (take && !sub_q && head_i.two) |=> sub_q)

endmodule

// File: sv/onewire_rom_search_engine.sv
// Search ROM decision engine. Push a begin request, then the presence report,
// then one bit/complement pair per ROM bit; pop the answers: bus reset, search
// command, direction bit to write, and finished with the ROM code and the
// last-device flag. A request is taken every cycle while full is low and its
// answers can be popped from the next cycle on. A request that yields two
// answers (the 64th bit) holds its queue slot for two pops. The result queue
// (QueueDepth requests) sets how far the request side may run ahead of pop.
module onewire_rom_search_engine import ros_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  req_t req_i,
  output logic empty,
  input  logic pop,
  output res_t res_o
);

  logic   accept;
  logic   q_push, q_pop;
  entry_t q_in, q_head;

  assign accept = push && !full;

  ros_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i),
    .push_o   (q_push),
    .entry_o  (q_in)
  );

  ros_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (empty)
  );

  ros_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (empty),
    .pop_i       (pop),
    .pop_entry_o (q_pop),
    .res_o       (res_o)
  );

endmodule

// File: dv/onewire_rom_search_engine_test.sv
`timescale 1ns / 100ps

module onewire_rom_search_engine_test import ros_pkg::*;;

  localparam logic [1:0]  FuncUnused = 2'd3;
  localparam int unsigned ItemTarget = 1820;
  localparam int unsigned QuietFrom  = 1500;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned MaxDevices = 4;

  typedef struct {
    req_t req;
    bit   typed;
    res_t want;
  } plan_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  req_t req_in = '0;
  logic full;
  logic empty;
  res_t res_out;

  // Predictor state
  logic [6:0]  dsc_pos;
  logic [3:0]  fam_pos;
  logic        bus_done;
  logic [63:0] rom_reg;
  logic [7:0]  crc_reg;
  logic [6:0]  bit_at;
  logic [6:0]  zero_at;
  phase_e      phase_now;
  bit          dir_taken;

  res_t        answers_due[$];
  plan_row_t   plan[$];

  // Simulated bus population
  logic [63:0] dev_rom[MaxDevices];
  int unsigned n_dev;

  int unsigned errors = 0;
  int unsigned acted = 0;
  int unsigned cycles = 0;
  bit          gaps_on = 1'b1;
  bit          pop_stalls = 1'b1;
  int unsigned pop_hold = 0;

  onewire_rom_search_engine DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .req_i  (req_in),
    .empty  (empty),
    .pop    (pop),
    .res_o  (res_out)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] b;
    logic       fb;
    c = acc;
    b = data;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[0];
      c  = c >> 1;
      b  = b >> 1;
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (errors < 40) begin
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    end
    errors++;
  endtask

  task automatic queue_answer(input kind_e k, input bit d, input bit f, input bit ld,
                              input bit last);
    res_t a;
    a = res_t'({k, d, f, rom_reg, ld, fam_pos, last});
    answers_due.push_back(a);
  endtask

  task automatic forget_branches();
    dsc_pos  = '0;
    fam_pos  = '0;
    bus_done = 1'b0;
  endtask

  task automatic give_up();
    forget_branches();
    phase_now = PH_IDLE;
    queue_answer(KIND_FINISH, 1'b0, 1'b0, 1'b0, 1'b1);
  endtask

  // Work out the answers to one accepted request and advance the search state.
  task automatic search_decide(input req_t r, output int unsigned made);
    int unsigned idx;
    bit          d;
    made = 0;
    case (r.func)
      FUNC_BEGIN: begin
        if (r.restart) begin
          forget_branches();
        end
        bit_at  = 7'd1;
        zero_at = '0;
        crc_reg = '0;
        if (bus_done) begin
          give_up();
        end else begin
          phase_now = PH_PRESENCE;
          queue_answer(KIND_RESET, 1'b0, 1'b0, 1'b0, 1'b1);
        end
        made = 1;
      end
      FUNC_PRESENCE: begin
        if (phase_now == PH_PRESENCE) begin
          if (!r.present) begin
            give_up();
          end else begin
            phase_now = PH_SEARCH;
            queue_answer(KIND_SEARCH, 1'b0, 1'b0, 1'b0, 1'b1);
          end
          made = 1;
        end
      end
      FUNC_PAIR: begin
        if (phase_now == PH_SEARCH) begin
          made = 1;
          if (r.id_bit && r.cmp_bit) begin
            give_up();
          end else begin
            if (bit_at < 1 || bit_at > RomBits) begin
              bit_at = 7'd1;
            end
            idx = bit_at - 1;
            if (r.id_bit != r.cmp_bit) begin
              d = r.id_bit;
            end else begin
              // Both values present: follow the previous path below the last branch.
              if (bit_at < dsc_pos) begin
                d = rom_reg[idx];
              end else begin
                d = (bit_at == dsc_pos);
              end
              if (!d) begin
                zero_at = bit_at;
                if (zero_at < FamilyLimit) begin
                  fam_pos = zero_at[3:0];
                end
              end
            end
            rom_reg[idx] = d;
            dir_taken    = d;
            bit_at++;
            if (idx % 8 == 7) begin
              crc_reg = crc_step(crc_reg, rom_reg[idx -: 8]);
            end
            if (bit_at <= RomBits) begin
              queue_answer(KIND_DIR, d, 1'b0, 1'b0, 1'b1);
            end else begin
              queue_answer(KIND_DIR, d, 1'b0, 1'b0, 1'b0);
              made      = 2;
              phase_now = PH_IDLE;
              if (crc_reg == 8'd0 && rom_reg[7:0] != 8'd0) begin
                dsc_pos = zero_at;
                if (dsc_pos == 0) begin
                  bus_done = 1'b1;
                end
                queue_answer(KIND_FINISH, 1'b0, 1'b1, bus_done, 1'b1);
              end else begin
                give_up();
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // Push one request, wait for it to be taken, and predict its answers.
  task automatic deliver(input req_t r, input bit typed, input res_t want);
    int unsigned made;
    if (gaps_on && acted < QuietFrom && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    push   <= 1'b1;
    req_in <= r;
    do @(posedge clk_i); while (full);
    search_decide(r, made);
    if (typed) begin
      answers_due[answers_due.size() - 1] = want;
    end
    if (made != 0) begin
      acted++;
    end
  endtask

  task automatic add_row(input logic [1:0] f, input bit rs, input bit pr, input bit ib,
                         input bit cb, input bit typed, input kind_e k, input bit d,
                         input logic [63:0] rom);
    plan_row_t row;
    row.req   = req_t'({f, rs, pr, ib, cb});
    row.typed = typed;
    row.want  = res_t'({k, d, 1'b0, rom, 1'b0, 4'd0, 1'b1});
    plan.push_back(row);
  endtask

  task automatic make_bus();
    int unsigned sel;
    logic [7:0]  c;
    n_dev = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, MaxDevices);
    for (int i = 0; i < MaxDevices; i++) begin
      sel = $urandom_range(0, 15);
      dev_rom[i] = {$urandom, $urandom};
      if (sel == 0) begin
        dev_rom[i] = '1;
      end else if (sel == 1) begin
        dev_rom[i][7:0] = 8'h00;
      end else if (sel == 2) begin
        dev_rom[i] = 64'h1;
      end
      c = '0;
      for (int k = 0; k < 7; k++) begin
        c = crc_step(c, dev_rom[i][8*k +: 8]);
      end
      dev_rom[i][63:56] = c;
      if (sel == 3) begin
        dev_rom[i][63:56] = c ^ 8'($urandom_range(1, 255));
      end
    end
  endtask

  task automatic run_search(input bit first);
    req_t        r;
    bit          ib;
    bit          cb;
    bit [3:0]    alive;
    int unsigned roll;
    r = req_t'($urandom_range(0, 63));
    r.func    = FUNC_BEGIN;
    r.restart = first;
    deliver(r, 1'b0, '0);
    if (phase_now != PH_PRESENCE) begin
      return;
    end
    if ($urandom_range(0, 19) == 0) begin
      r = req_t'($urandom_range(0, 63));
      r.func = FUNC_PAIR;
      deliver(r, 1'b0, '0);
    end
    r = req_t'($urandom_range(0, 63));
    r.func    = FUNC_PRESENCE;
    r.present = (n_dev != 0);
    if ($urandom_range(0, 29) == 0) begin
      r.present = ~r.present;
    end
    deliver(r, 1'b0, '0);
    if (phase_now != PH_SEARCH) begin
      return;
    end
    alive = '0;
    for (int i = 0; i < n_dev; i++) begin
      alive[i] = 1'b1;
    end
    for (int b = 0; b < RomBits; b++) begin
      // Wired-AND of every device still on the path.
      ib = 1'b1;
      cb = 1'b1;
      for (int i = 0; i < n_dev; i++) begin
        if (alive[i]) begin
          ib &= dev_rom[i][b];
          cb &= ~dev_rom[i][b];
        end
      end
      roll = $urandom_range(0, 399);
      if (roll < 2) begin
        r = req_t'($urandom_range(0, 63));
        r.func = FUNC_BEGIN;
        deliver(r, 1'b0, '0);
        return;
      end
      if (roll < 8) begin
        r = req_t'($urandom_range(0, 63));
        r.func = roll[0] ? FuncUnused : FUNC_PRESENCE;
        deliver(r, 1'b0, '0);
      end
      r = req_t'($urandom_range(0, 63));
      r.func    = FUNC_PAIR;
      r.id_bit  = ib;
      r.cmp_bit = cb;
      if (roll < 12) begin
        r.id_bit  = 1'($urandom_range(0, 1));
        r.cmp_bit = 1'($urandom_range(0, 1));
      end
      deliver(r, 1'b0, '0);
      if (phase_now != PH_SEARCH) begin
        return;
      end
      // Drop devices that took the other branch.
      for (int i = 0; i < n_dev; i++) begin
        if (alive[i] && dev_rom[i][b] != dir_taken) begin
          alive[i] = 1'b0;
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (answers_due.size() == 0) begin
          note_mismatch("answer with nothing pending", res_out.rom_code, '0);
        end else begin
          want = answers_due.pop_front();
          if (res_out.kind !== want.kind)
            note_mismatch("kind", 64'(res_out.kind), 64'(want.kind));
          if (res_out.dir_bit !== want.dir_bit)
            note_mismatch("dir_bit", 64'(res_out.dir_bit), 64'(want.dir_bit));
          if (res_out.found !== want.found)
            note_mismatch("found", 64'(res_out.found), 64'(want.found));
          if (res_out.rom_code !== want.rom_code)
            note_mismatch("rom_code", res_out.rom_code, want.rom_code);
          if (res_out.was_last_device !== want.was_last_device)
            note_mismatch("was_last_device", 64'(res_out.was_last_device),
                          64'(want.was_last_device));
          if (res_out.family_branch !== want.family_branch)
            note_mismatch("family_branch", 64'(res_out.family_branch),
                          64'(want.family_branch));
          if (res_out.last_of_run !== want.last_of_run)
            note_mismatch("last_of_run", 64'(res_out.last_of_run), 64'(want.last_of_run));
        end
      end
      if (pop_hold > 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else if (pop_stalls && acted < QuietFrom && $urandom_range(0, 5) == 0) begin
        pop_hold = $urandom_range(0, 4);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("onewire_rom_search_engine_test: errors");
      $finish;
    end
  end

  initial begin
    dsc_pos   = '0;
    fam_pos   = '0;
    bus_done  = 1'b0;
    rom_reg   = '0;
    crc_reg   = '0;
    bit_at    = 7'd1;
    zero_at   = '0;
    phase_now = PH_IDLE;
    dir_taken = 1'b0;

    // Idle, awaiting presence, search, failure and restart corners.
    add_row(FUNC_PAIR,     1'b0, 1'b0, 1'b1, 1'b0, 1'b0, KIND_RESET,  1'b0, 64'h0);
    add_row(FUNC_PRESENCE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, KIND_RESET,  1'b0, 64'h0);
    add_row(FuncUnused,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, KIND_RESET,  1'b0, 64'h0);
    add_row(FUNC_BEGIN,    1'b0, 1'b1, 1'b1, 1'b1, 1'b1, KIND_RESET,  1'b0, 64'h0);
    add_row(FUNC_PAIR,     1'b1, 1'b1, 1'b0, 1'b1, 1'b0, KIND_RESET,  1'b0, 64'h0);
    add_row(FUNC_PRESENCE, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, KIND_FINISH, 1'b0, 64'h0);
    add_row(FUNC_BEGIN,    1'b1, 1'b0, 1'b0, 1'b0, 1'b1, KIND_RESET,  1'b0, 64'h0);
    add_row(FUNC_PRESENCE, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, KIND_SEARCH, 1'b0, 64'h0);
    add_row(FUNC_PAIR,     1'b0, 1'b0, 1'b1, 1'b0, 1'b1, KIND_DIR,    1'b1, 64'h1);
    add_row(FUNC_PAIR,     1'b1, 1'b1, 1'b0, 1'b1, 1'b1, KIND_DIR,    1'b0, 64'h1);
    add_row(FUNC_PAIR,     1'b0, 1'b1, 1'b0, 1'b0, 1'b0, KIND_RESET,  1'b0, 64'h0);
    add_row(FUNC_PRESENCE, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, KIND_RESET,  1'b0, 64'h0);
    add_row(FUNC_PAIR,     1'b1, 1'b0, 1'b1, 1'b1, 1'b0, KIND_RESET,  1'b0, 64'h0);
    add_row(FUNC_PAIR,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, KIND_RESET,  1'b0, 64'h0);
    add_row(FUNC_BEGIN,    1'b0, 1'b0, 1'b1, 1'b0, 1'b1, KIND_RESET,  1'b0, 64'h1);
    add_row(FUNC_PRESENCE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, KIND_SEARCH, 1'b0, 64'h1);
    add_row(FUNC_PAIR,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, KIND_RESET,  1'b0, 64'h0);
    add_row(FUNC_BEGIN,    1'b1, 1'b1, 1'b1, 1'b1, 1'b0, KIND_RESET,  1'b0, 64'h0);
    add_row(FUNC_PRESENCE, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, KIND_RESET,  1'b0, 64'h0);
    add_row(FUNC_PAIR,     1'b1, 1'b1, 1'b1, 1'b1, 1'b0, KIND_RESET,  1'b0, 64'h0);
    add_row(FuncUnused,    1'b1, 1'b1, 1'b1, 1'b1, 1'b0, KIND_RESET,  1'b0, 64'h0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      deliver(plan[i].req, plan[i].typed, plan[i].want);
    end

    while (acted < ItemTarget) begin
      make_bus();
      gaps_on    = ($urandom_range(0, 3) != 0);
      pop_stalls = ($urandom_range(0, 3) != 0);
      for (int s = 0; s < n_dev + 2; s++) begin
        if (acted < ItemTarget) begin
          run_search(s == 0 || $urandom_range(0, 9) == 0);
        end
      end
    end
    push <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("onewire_rom_search_engine_test: clean");
    end else begin
      $display("onewire_rom_search_engine_test: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/ros_pkg.sv
sv/ros_front.sv
sv/ros_queue.sv
sv/ros_back.sv
sv/onewire_rom_search_engine.sv
dv/onewire_rom_search_engine_test.sv
